// ----- src/source_token_lexer_macros.svh -----
// ----------------------------------------------------------------------------
// Source token lexer assertion macros
// Shared concurrent assertion forms for the lexer checkers.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKEN_LEXER_MACROS_SVH
`define SOURCE_TOKEN_LEXER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// Source token lexer package
// Token kinds, keyword tables, character codes and result record type.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int S_TDATA_BITS = 8;
    localparam int M_TDATA_BITS = 72;
    localparam int OUT_BITS     = 16;
    localparam logic [OUT_BITS-1:0] OUT_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        K_EXIT   = 4'd0,
        K_ASSIGN = 4'd1,
        K_PRINT  = 4'd2,
        K_SEMI   = 4'd3,
        K_OPEN   = 4'd4,
        K_CLOSE  = 4'd5,
        K_STRING = 4'd6,
        K_NAME   = 4'd7,
        K_NUMBER = 4'd8,
        K_END    = 4'd9,
        K_ERROR  = 4'd10
    } t_kind;

    typedef enum logic [1:0] {
        KW_EXIT   = 2'd0,
        KW_ASSIGN = 2'd1,
        KW_PRINT  = 2'd2
    } t_kw;

    typedef struct packed {
        t_kind               kind;
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] len;
        logic [OUT_BITS-1:0] line;
        logic [OUT_BITS-1:0] col;
    } t_token;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_LOW_I = 8'h69;
    localparam logic [7:0] CH_LOW_T = 8'h74;
    localparam logic [7:0] CH_LOW_P = 8'h70;
    localparam logic [7:0] CH_LOW_R = 8'h72;
    localparam logic [7:0] CH_LOW_N = 8'h6E;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    function automatic logic [2:0] kw_len(t_kw k);
        logic [2:0] r;
        unique case (k)
            KW_EXIT:   r = 3'd4;
            KW_ASSIGN: r = 3'd2;
            KW_PRINT:  r = 3'd5;
            default:   r = 3'd4;
        endcase
        return r;
    endfunction

    function automatic t_kind kw_kind(t_kw k);
        t_kind r;
        unique case (k)
            KW_EXIT:   r = K_EXIT;
            KW_ASSIGN: r = K_ASSIGN;
            KW_PRINT:  r = K_PRINT;
            default:   r = K_EXIT;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(t_kw k, logic [2:0] m);
        logic [7:0] r;
        r = 8'h00;
        unique case (k)
            KW_EXIT: begin
                unique case (m)
                    3'd0:    r = CH_LOW_E;
                    3'd1:    r = CH_LOW_X;
                    3'd2:    r = CH_LOW_I;
                    3'd3:    r = CH_LOW_T;
                    default: r = 8'h00;
                endcase
            end
            KW_ASSIGN: begin
                unique case (m)
                    3'd0:    r = CH_COLON;
                    3'd1:    r = CH_EQUAL;
                    default: r = 8'h00;
                endcase
            end
            KW_PRINT: begin
                unique case (m)
                    3'd0:    r = CH_LOW_P;
                    3'd1:    r = CH_LOW_R;
                    3'd2:    r = CH_LOW_I;
                    3'd3:    r = CH_LOW_N;
                    3'd4:    r = CH_LOW_T;
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- src/source_token_lexer.sv -----
// ----------------------------------------------------------------------------
// Source token lexer
// Streams source bytes in and emits keyword, punctuation, string, name,
// number, end and error tokens with offset, length, line and column.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                                     tlast
// s_axis    in   source byte [7:0]                         end of source
// m_axis    out  kind, start, length, line, column [67:0]  last token of byte
//
// A byte is lexed combinationally between the input register and the token
// bundle register; a byte that yields no token needs no output slot. A byte's
// tokens go out one per cycle while m_axis is ready, the next token-bearing
// byte waiting in the input register; throughput is one byte per cycle when
// each byte gives at most one token and m_axis is ready. Reset is synchronous
// and active low and clears all control state; there is no clearing pass.
// Stalls on m_axis back up through the bundle and input registers to s_axis.
// ----------------------------------------------------------------------------
module source_token_lexer #(
    parameter int POSITION_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // source_byte [7:0]
    input  logic [stl_pkg::S_TDATA_BITS-1:0]  i_s_axis_tdata,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // token_kind [3:0], start_offset [19:4], token_length [35:20],
    // line_number [51:36], column_number [67:52], zero [71:68]
    output logic [stl_pkg::M_TDATA_BITS-1:0]  o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);
    import stl_pkg::*;

    localparam int P       = POSITION_BITS;
    localparam int EXT     = (P > OUT_BITS) ? P : OUT_BITS;
    localparam int SLOTS   = 4;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = IDX_W + 1;

    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_KEY    = 6'b000010,
        MODE_STRING = 6'b000100,
        MODE_NAME   = 6'b001000,
        MODE_NUMBER = 6'b010000,
        MODE_ERROR  = 6'b100000
    } t_mode;

    t_mode              r_mode, n_mode;
    t_kw                r_kw, n_kw;
    logic [2:0]         r_mpos, n_mpos;
    logic [P-1:0]       r_read_pos, n_read_pos;
    logic [P-1:0]       r_tok_start, n_tok_start;
    logic [P-1:0]       r_cur_line, n_cur_line;
    logic [P-1:0]       r_cur_col, n_cur_col;
    logic [P-1:0]       r_start_line, n_start_line;
    logic [P-1:0]       r_start_col, n_start_col;

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_eos;

    t_token             r_tok [SLOTS];
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_idx;
    logic               r_out_valid;

    t_token             n_tok [SLOTS];
    logic [CNT_W-1:0]   n_cnt;

    logic               w_out_last;
    logic               w_out_free;
    logic               w_advance;
    logic               w_accept;

    function automatic logic [P-1:0] sat_inc(logic [P-1:0] v);
        return (v == {P{1'b1}}) ? v : v + {{(P-1){1'b0}}, 1'b1};
    endfunction

    function automatic logic [OUT_BITS-1:0] clamp_out(logic [P-1:0] v);
        logic [EXT-1:0] e;
        e = EXT'(v);
        return (e > EXT'(OUT_MAX)) ? OUT_MAX : e[OUT_BITS-1:0];
    endfunction

    function automatic t_token make_token(t_kind kind, logic [P-1:0] start,
                                          logic [P-1:0] len, logic [P-1:0] line,
                                          logic [P-1:0] col);
        t_token t;
        t.kind  = kind;
        t.start = clamp_out(start);
        t.len   = clamp_out(len);
        t.line  = clamp_out(line);
        t.col   = clamp_out(col);
        return t;
    endfunction

    always_comb begin
        logic [7:0]   b;
        logic         last;
        logic         go;
        logic         is_sp;
        logic         is_alpha;
        logic         is_digit;
        logic [P-1:0] p;
        logic [P-1:0] cs;
        t_kw          k;
        logic [2:0]   m1;

        b    = r_in_byte;
        last = r_in_eos;
        p    = r_read_pos;

        is_sp    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        is_alpha = ((b >= CH_LOW_A) && (b <= CH_LOW_Z)) || ((b >= CH_UP_A) && (b <= CH_UP_Z));
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

        n_mode       = r_mode;
        n_kw         = r_kw;
        n_mpos       = r_mpos;
        n_tok_start  = r_tok_start;
        n_start_line = r_start_line;
        n_start_col  = r_start_col;
        n_cur_line   = r_cur_line;
        n_cur_col    = r_cur_col;
        n_cnt        = '0;
        for (int i = 0; i < SLOTS; i++) begin
            n_tok[i] = '0;
        end

        if (b == CH_NL) begin
            n_cur_line = sat_inc(r_cur_line);
            n_cur_col  = '0;
        end else begin
            n_cur_col = sat_inc(r_cur_col);
        end
        n_read_pos = sat_inc(p);

        go = 1'b1;
        k  = r_kw;
        m1 = r_mpos + 3'd1;
        cs = sat_inc(r_tok_start);

        if (n_mode == MODE_KEY) begin
            go = 1'b0;
            if ((r_mpos < kw_len(k)) && (b == kw_char(k, r_mpos))) begin
                n_mpos = m1;
                if (m1 == kw_len(k)) begin
                    n_kw   = KW_EXIT;
                    n_mpos = '0;
                    if (!last) begin
                        n_tok[n_cnt[IDX_W-1:0]] = make_token(kw_kind(k), n_tok_start,
                            P'(kw_len(k)), n_start_line, n_start_col);
                        n_cnt  = n_cnt + 1'b1;
                        n_mode = MODE_IDLE;
                    end else if (k == KW_ASSIGN) begin
                        n_tok[n_cnt[IDX_W-1:0]] = make_token(K_ERROR, n_tok_start, '0,
                            n_start_line, n_start_col);
                        n_cnt  = n_cnt + 1'b1;
                        n_mode = MODE_ERROR;
                    end else begin
                        n_mode = MODE_NAME;
                    end
                end
            end else begin
                n_kw   = KW_EXIT;
                n_mpos = '0;
                if (k == KW_ASSIGN) begin
                    n_tok[n_cnt[IDX_W-1:0]] = make_token(K_ERROR, n_tok_start, '0,
                        n_start_line, n_start_col);
                    n_cnt  = n_cnt + 1'b1;
                    n_mode = MODE_ERROR;
                end else begin
                    n_mode = MODE_NAME;
                    go     = 1'b1;
                end
            end
        end

        if (go && ((n_mode == MODE_NAME) || (n_mode == MODE_NUMBER))) begin
            if (is_digit || ((n_mode == MODE_NAME) && is_alpha)) begin
                go = 1'b0;
            end else begin
                n_tok[n_cnt[IDX_W-1:0]] = make_token(
                    (n_mode == MODE_NAME) ? K_NAME : K_NUMBER, n_tok_start,
                    p - n_tok_start, n_start_line, n_start_col);
                n_cnt  = n_cnt + 1'b1;
                n_mode = MODE_IDLE;
            end
        end

        if (go) begin
            unique case (n_mode)
                MODE_IDLE: begin
                    if (!is_sp) begin
                        n_tok_start  = p;
                        n_start_line = n_cur_line;
                        n_start_col  = n_cur_col;
                        if (b == CH_LOW_E) begin
                            n_kw   = KW_EXIT;
                            n_mpos = 3'd1;
                            n_mode = MODE_KEY;
                        end else if (b == CH_COLON) begin
                            n_kw   = KW_ASSIGN;
                            n_mpos = 3'd1;
                            n_mode = MODE_KEY;
                        end else if (b == CH_LOW_P) begin
                            n_kw   = KW_PRINT;
                            n_mpos = 3'd1;
                            n_mode = MODE_KEY;
                        end else if (b == CH_SEMI) begin
                            n_tok[n_cnt[IDX_W-1:0]] = make_token(K_SEMI, p, P'(1),
                                n_cur_line, n_cur_col);
                            n_cnt = n_cnt + 1'b1;
                        end else if (b == CH_OPEN) begin
                            n_tok[n_cnt[IDX_W-1:0]] = make_token(K_OPEN, p, P'(1),
                                n_cur_line, n_cur_col);
                            n_cnt = n_cnt + 1'b1;
                        end else if (b == CH_CLOSE) begin
                            n_tok[n_cnt[IDX_W-1:0]] = make_token(K_CLOSE, p, P'(1),
                                n_cur_line, n_cur_col);
                            n_cnt = n_cnt + 1'b1;
                        end else if (b == CH_QUOTE) begin
                            n_mode = MODE_STRING;
                        end else if (is_alpha) begin
                            n_mode = MODE_NAME;
                        end else if (is_digit) begin
                            n_mode = MODE_NUMBER;
                        end else begin
                            n_tok[n_cnt[IDX_W-1:0]] = make_token(K_ERROR, p, '0,
                                n_cur_line, n_cur_col);
                            n_cnt  = n_cnt + 1'b1;
                            n_mode = MODE_ERROR;
                            n_kw   = KW_EXIT;
                            n_mpos = '0;
                        end
                    end
                end
                MODE_STRING: begin
                    if (b == CH_QUOTE) begin
                        n_tok[n_cnt[IDX_W-1:0]] = make_token(K_STRING, cs,
                            (p > cs) ? p - cs : '0, n_start_line, n_start_col);
                        n_cnt  = n_cnt + 1'b1;
                        n_mode = MODE_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end

        if (last) begin
            if (n_mode == MODE_KEY) begin
                if (n_kw == KW_ASSIGN) begin
                    n_tok[n_cnt[IDX_W-1:0]] = make_token(K_ERROR, n_tok_start, '0,
                        n_start_line, n_start_col);
                end else begin
                    n_tok[n_cnt[IDX_W-1:0]] = make_token(K_NAME, n_tok_start,
                        n_read_pos - n_tok_start, n_start_line, n_start_col);
                end
                n_cnt = n_cnt + 1'b1;
            end else if ((n_mode == MODE_NAME) || (n_mode == MODE_NUMBER)) begin
                n_tok[n_cnt[IDX_W-1:0]] = make_token(
                    (n_mode == MODE_NAME) ? K_NAME : K_NUMBER, n_tok_start,
                    n_read_pos - n_tok_start, n_start_line, n_start_col);
                n_cnt = n_cnt + 1'b1;
            end else if (n_mode == MODE_STRING) begin
                n_tok[n_cnt[IDX_W-1:0]] = make_token(K_ERROR, n_tok_start, '0,
                    n_start_line, n_start_col);
                n_cnt = n_cnt + 1'b1;
            end
            if (n_cnt < CNT_W'(SLOTS)) begin
                n_tok[n_cnt[IDX_W-1:0]] = make_token(K_END, n_read_pos, '0,
                    n_cur_line, n_cur_col);
                n_cnt = n_cnt + 1'b1;
            end
            n_mode       = MODE_IDLE;
            n_kw         = KW_EXIT;
            n_mpos       = '0;
            n_read_pos   = '0;
            n_tok_start  = '0;
            n_cur_line   = P'(1);
            n_cur_col    = '0;
            n_start_line = P'(1);
            n_start_col  = '0;
        end
    end

    assign w_out_last      = ({1'b0, r_idx} == (r_cnt - 1'b1));
    assign w_out_free      = !r_out_valid || (i_m_axis_tready && w_out_last);
    assign w_advance       = r_in_valid && ((n_cnt == '0) || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_mode       <= MODE_IDLE;
            r_kw         <= KW_EXIT;
            r_mpos       <= '0;
            r_read_pos   <= '0;
            r_tok_start  <= '0;
            r_cur_line   <= P'(1);
            r_cur_col    <= '0;
            r_start_line <= P'(1);
            r_start_col  <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_mode       <= n_mode;
                r_kw         <= n_kw;
                r_mpos       <= n_mpos;
                r_read_pos   <= n_read_pos;
                r_tok_start  <= n_tok_start;
                r_cur_line   <= n_cur_line;
                r_cur_col    <= n_cur_col;
                r_start_line <= n_start_line;
                r_start_col  <= n_start_col;
            end
            if (w_advance && (n_cnt != '0)) begin
                r_out_valid <= 1'b1;
                r_cnt       <= n_cnt;
                r_idx       <= '0;
            end else if (r_out_valid && i_m_axis_tready) begin
                if (w_out_last) begin
                    r_out_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eos  <= i_s_axis_tlast;
        end
        if (w_advance && (n_cnt != '0)) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_tok[i] <= n_tok[i];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = w_out_last;
    assign o_m_axis_tdata  = {4'b0000, r_tok[r_idx].col, r_tok[r_idx].line,
                              r_tok[r_idx].len, r_tok[r_idx].start, r_tok[r_idx].kind};

endmodule

// ----- src/stl_checker.sv -----
// ----------------------------------------------------------------------------
// Source token lexer checker
// Port-level assertions on the token stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "source_token_lexer_macros.svh"

module stl_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [stl_pkg::M_TDATA_BITS-1:0]  o_m_axis_tdata,
    input  logic                              o_m_axis_tlast
);
    import stl_pkg::*;

    logic w_is_end;
    logic w_is_error;

    assign w_is_end   = o_m_axis_tvalid && (o_m_axis_tdata[3:0] == K_END);
    assign w_is_error = o_m_axis_tvalid && (o_m_axis_tdata[3:0] == K_ERROR);

    `STL_ASSERT_SAME(a_end_is_last, i_clk, i_rst_n, w_is_end, o_m_axis_tlast, "end token not last of its byte")
    `STL_ASSERT_SAME(a_empty_len, i_clk, i_rst_n, w_is_end || w_is_error, o_m_axis_tdata[35:20] == 16'd0, "end or error token with nonzero length")
    `STL_ASSERT_SAME(a_line_nonzero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[51:36] != 16'd0, "token reports line zero")
    `STL_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled token changed")

endmodule

bind source_token_lexer stl_checker u_stl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
